// File: hw/rtl/tpmq_pkg.sv
`timescale 1ns / 1ps

package tpmq_pkg;

	localparam int LEVELS      = 4;
	localparam int LEVEL_DEPTH = 16;
	localparam int HANDLE_BITS = 16;

	localparam int TIME_BITS   = 40;
	localparam int PORT_HANDLE_BITS = 16;
	localparam int PORT_PRI_BITS    = 2;
	localparam int PORT_TOTAL_BITS  = 7;

	localparam int SLOT_COUNT = LEVELS * LEVEL_DEPTH;
	localparam int SLOT_AW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int LV_W       = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int FILL_W     = $clog2(LEVEL_DEPTH + 1);
	localparam int TOT_W      = $clog2(SLOT_COUNT + 1);

	localparam logic KIND_PUSH = 1'b0;
	localparam logic KIND_POP  = 1'b1;

	localparam logic [1:0] STATUS_OK      = 2'd0;
	localparam logic [1:0] STATUS_DROPPED = 2'd1;
	localparam logic [1:0] STATUS_EMPTY   = 2'd2;

	typedef struct packed {
		logic [HANDLE_BITS-1:0] handle;
		logic [TIME_BITS-1:0]   release_time;
	} slot_word_t;

	typedef struct packed {
		logic              we;
		logic [SLOT_AW-1:0] waddr;
		slot_word_t        wdata;
		logic [SLOT_AW-1:0] raddr;
	} slot_req_t;

	function automatic logic [SLOT_AW-1:0] slot_addr(input logic [LV_W-1:0] lv,
		input logic [FILL_W-1:0] k);
		logic [SLOT_AW-1:0] base;
		base = SLOT_AW'(lv) * SLOT_AW'(LEVEL_DEPTH);
		return base + SLOT_AW'(k);
	endfunction

endpackage

// File: hw/rtl/tpmq_if.sv
`timescale 1ns / 1ps

interface tpmq_in_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  kind;
	logic [tpmq_pkg::PORT_PRI_BITS-1:0]    priority_req;
	logic [tpmq_pkg::PORT_HANDLE_BITS-1:0] handle;
	logic [tpmq_pkg::TIME_BITS-1:0]        release_time;
	logic [tpmq_pkg::TIME_BITS-1:0]        current_time;

	modport source (output valid, kind, priority_req, handle, release_time, current_time,
		input ready);
	modport sink (input valid, kind, priority_req, handle, release_time, current_time,
		output ready);
endinterface

interface tpmq_out_if;
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            status;
	logic [tpmq_pkg::PORT_HANDLE_BITS-1:0] out_handle;
	logic [tpmq_pkg::PORT_PRI_BITS-1:0]    out_priority;
	logic [tpmq_pkg::PORT_TOTAL_BITS-1:0]  total_count;
	logic                                  any_pending;
	logic                                  wake_sender;

	modport source (output valid, status, out_handle, out_priority, total_count,
		any_pending, wake_sender, input ready);
	modport sink (input valid, status, out_handle, out_priority, total_count,
		any_pending, wake_sender, output ready);
endinterface

// File: hw/rtl/tpmq_slots.sv
`timescale 1ns / 1ps

module tpmq_slots (
	input  logic                 clk,
	input  tpmq_pkg::slot_req_t  req,
	output tpmq_pkg::slot_word_t rdata
);
	import tpmq_pkg::*;

	slot_word_t mem_q [SLOT_COUNT];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata <= mem_q[req.raddr];
	end

endmodule

// File: hw/rtl/timed_priority_message_queue.sv
`timescale 1ns / 1ps

// Timed strict-priority message queue, one FIFO per level, level 0 most urgent.
// in_ch carries push (kind 0) and pop (kind 1) items, out_ch one result per item;
// both are valid/ready channels, an item moves on a transfer with both high.
// A push that fits its level writes the slot and bumps the fill count at the accept
// edge, where its result is also registered; S_DONE then moves it to the output register.
// A pop walks the levels through the one-write, one-read slot memory, per entry
// examined a read (S_SCAN_RD), then a compare of release time against current time
// (S_SCAN_CHK), moving to the next level when one is exhausted; on a hit it closes
// up the level with a read and a write per entry moved behind it (S_SHIFT_RD,
// S_SHIFT_WR), then posts the result from S_DONE.
// in_ch.ready is high only when no item is in progress; one item at a time.
// The finished result sits in an output register; the next item is taken while
// it waits, and that item's result holds in the sequencer until out_ch takes
// the previous one, so a stalled receiver just stops the queue.
// Reset clears the fill counts, the total and the output valid; slot contents
// are not cleared and no clearing pass is needed.
module timed_priority_message_queue (
	input logic       clk,
	input logic       arst_n,
	tpmq_in_if.sink   in_ch,
	tpmq_out_if.source out_ch
);
	import tpmq_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN_RD  = 3'd1;
	localparam logic [2:0] S_SCAN_CHK = 3'd2;
	localparam logic [2:0] S_SHIFT_RD = 3'd3;
	localparam logic [2:0] S_SHIFT_WR = 3'd4;
	localparam logic [2:0] S_DONE     = 3'd5;

	logic [2:0]             state_q;
	logic [FILL_W-1:0]      fill_q [LEVELS];
	logic [TOT_W-1:0]       total_q;
	logic [LV_W-1:0]        lv_q;
	logic [FILL_W-1:0]      k_q;
	logic [FILL_W-1:0]      j_q;
	logic [TIME_BITS-1:0]   now_q;

	logic [1:0]             res_status_q;
	logic [HANDLE_BITS-1:0] res_handle_q;
	logic [LV_W-1:0]        res_pri_q;
	logic                   res_wake_q;

	logic                   out_valid_q;
	logic [1:0]             out_status_q;
	logic [HANDLE_BITS-1:0] out_handle_q;
	logic [LV_W-1:0]        out_pri_q;
	logic [TOT_W-1:0]       out_total_q;
	logic                   out_wake_q;

	slot_req_t              req;
	slot_word_t             rdata;

	logic                   in_xfer;
	logic                   pri_ok;
	logic [LV_W-1:0]        push_lv;
	logic                   push_ok;
	logic [FILL_W-1:0]      cur_fill;
	logic                   eligible;
	logic                   out_load;
	logic [FILL_W-1:0]      j_next;
	logic [TOT_W-1:0]       fill_sum;

	tpmq_slots u_slots (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign pri_ok      = 32'(in_ch.priority_req) < LEVELS;
	assign push_lv     = LV_W'(in_ch.priority_req);
	assign push_ok     = pri_ok && (32'(fill_q[push_lv]) < LEVEL_DEPTH);
	assign cur_fill    = fill_q[lv_q];
	assign eligible    = (rdata.release_time == '0) || (rdata.release_time <= now_q);
	assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ch.ready);
	assign j_next      = j_q + FILL_W'(1);

	always_comb begin
		req.we    = 1'b0;
		req.waddr = slot_addr(push_lv, fill_q[push_lv]);
		req.wdata.handle       = HANDLE_BITS'(in_ch.handle);
		req.wdata.release_time = in_ch.release_time;
		req.raddr = slot_addr(lv_q, k_q);
		case (state_q)
			S_IDLE: begin
				req.we = in_xfer && (in_ch.kind == KIND_PUSH) && push_ok;
			end
			S_SHIFT_RD: begin
				req.raddr = slot_addr(lv_q, j_next);
			end
			S_SHIFT_WR: begin
				req.we    = 1'b1;
				req.waddr = slot_addr(lv_q, j_q);
				req.wdata = rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			for (int i = 0; i < LEVELS; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (in_ch.kind == KIND_PUSH) begin
							if (push_ok) begin
								fill_q[push_lv] <= fill_q[push_lv] + FILL_W'(1);
								total_q         <= total_q + TOT_W'(1);
							end
							state_q <= S_DONE;
						end else begin
							state_q <= S_SCAN_RD;
						end
					end
				end
				S_SCAN_RD: begin
					if (k_q < cur_fill) begin
						state_q <= S_SCAN_CHK;
					end else if (lv_q == LV_W'(LEVELS - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_SCAN_CHK: begin
					state_q <= eligible ? S_SHIFT_RD : S_SCAN_RD;
				end
				S_SHIFT_RD: begin
					if (j_next < cur_fill) begin
						state_q <= S_SHIFT_WR;
					end else begin
						fill_q[lv_q] <= cur_fill - FILL_W'(1);
						total_q      <= total_q - TOT_W'(1);
						state_q      <= S_DONE;
					end
				end
				S_SHIFT_WR: begin
					state_q <= S_SHIFT_RD;
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				lv_q         <= '0;
				k_q          <= '0;
				now_q        <= in_ch.current_time;
				res_handle_q <= '0;
				res_pri_q    <= '0;
				if (in_ch.kind == KIND_PUSH) begin
					res_status_q <= push_ok ? STATUS_OK : STATUS_DROPPED;
					res_wake_q   <= push_ok;
				end else begin
					res_status_q <= STATUS_EMPTY;
					res_wake_q   <= 1'b0;
				end
			end
			S_SCAN_RD: begin
				if (!(k_q < cur_fill) && (lv_q != LV_W'(LEVELS - 1))) begin
					lv_q <= lv_q + LV_W'(1);
					k_q  <= '0;
				end
			end
			S_SCAN_CHK: begin
				if (eligible) begin
					res_status_q <= STATUS_OK;
					res_handle_q <= rdata.handle;
					res_pri_q    <= lv_q;
					j_q          <= k_q;
				end else begin
					k_q <= k_q + FILL_W'(1);
				end
			end
			S_SHIFT_WR: begin
				j_q <= j_next;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_handle_q <= res_handle_q;
			out_pri_q    <= res_pri_q;
			out_total_q  <= total_q;
			out_wake_q   <= res_wake_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.status       = out_status_q;
	assign out_ch.out_handle   = PORT_HANDLE_BITS'(out_handle_q);
	assign out_ch.out_priority = PORT_PRI_BITS'(out_pri_q);
	assign out_ch.total_count  = PORT_TOTAL_BITS'(out_total_q);
	assign out_ch.any_pending  = (out_total_q != '0);
	assign out_ch.wake_sender  = out_wake_q;

	always_comb begin
		fill_sum = '0;
		for (int i = 0; i < LEVELS; i++) begin
			fill_sum = fill_sum + TOT_W'(fill_q[i]);
		end
	end

	a_total_matches_fill: assert property (@(posedge clk) disable iff (!arst_n)
		total_q == fill_sum)
		else $error("total count out of step with level fill counts");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !in_ch.ready)
		else $error("input taken while an item was still in progress");

	a_wake_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_wake_q |-> out_status_q == STATUS_OK && out_handle_q == '0)
		else $error("wake flagged on a result that is not an accepted push");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_fill) <= LEVEL_DEPTH)
		else $error("level fill count above level depth");

endmodule
